@@ rtl/overwrite_ring_buffer_macros.svh @@
// ---------------------------------------------------------------------------
// Overwrite ring buffer assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef OVERWRITE_RING_BUFFER_MACROS_SVH
`define OVERWRITE_RING_BUFFER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property at every clock edge outside reset.
`define ORB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define ORB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ORB_ASSERT(label, clk, rst, prop, msg)
`define ORB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/orb_pkg.sv @@
// ---------------------------------------------------------------------------
// Overwrite ring buffer package
// Widths, command and status codes, and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package orb_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CAP_W  = $clog2(DEPTH + 1);

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 7;
   localparam int STAT_W   = 2;
   localparam int CSR_W    = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = STAT_W + 1;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ERROR = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;   // take the request on the input channel
      logic step;     // emit the next byte of a streaming read
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // output register can be loaded this cycle
      logic stream;     // current request is a read that emits bytes
      logic count_one;  // one byte left in the streaming read
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/orb_ctrl.sv @@
// ---------------------------------------------------------------------------
// Overwrite ring buffer controller
// Two-state sequencer: take requests, or stream the bytes of a read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module orb_ctrl
   import orb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire dp_status_type status,
   output      ctrl_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_tready = (state_ff == ST_IDLE) && status.out_free;
   assign cmd.accept = req_tvalid && req_tready;
   assign cmd.step   = (state_ff == ST_READ) && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.stream) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // drop back once the final byte goes out
            if (cmd.step && status.count_one) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/orb_datapath.sv @@
// ---------------------------------------------------------------------------
// Overwrite ring buffer datapath
// Byte store, start/fill/count registers, capacity and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "overwrite_ring_buffer_macros.svh"

module orb_datapath
   import orb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [CMD_W-1:0]      req_tuser,
   input  wire ctrl_cmd_type          cmd,
   output      dp_status_type         status,
   input  wire logic                  csr_we,
   input  wire logic [CSR_W-1:0]      csr_wdata,
   input  wire logic                  rsp_tready,
   output      logic                  rsp_tvalid,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic [RSP_USER_W-1:0] rsp_tuser,
   output      logic                  rsp_tlast
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   logic [ADDR_W-1:0] start_ff, start_in;
   logic [CAP_W-1:0]  fill_ff, fill_in;
   logic [CAP_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] out_status_ff, out_status_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_dv_ff, out_dv_in;
   logic              out_last_ff, out_last_in;
   logic [CAP_W-1:0]  out_fill_ff, out_fill_in;

   logic [CMD_W-1:0]  cmd_code;
   logic [BYTE_W-1:0] byte_val;
   logic [LEN_W-1:0]  len_val;
   logic              err;
   logic [CAP_W:0]    wr_sum;
   logic [CAP_W:0]    wr_pos;
   logic [ADDR_W-1:0] wr_addr;
   logic              we;
   logic [CAP_W-1:0]  start_inc;
   logic [ADDR_W-1:0] start_adv;
   logic [CAP_W-1:0]  count_min;
   logic              load;

   assign cmd_code = req_tuser;
   assign byte_val = req_tdata[BYTE_W-1:0];
   assign len_val  = req_tdata[BYTE_W +: LEN_W];

   assign err = (cap_ff == '0) || (len_val > LEN_W'(cap_ff));

   // append position, wrapped once over the capacity in use
   assign wr_sum  = (CAP_W+1)'(start_ff) + (CAP_W+1)'(fill_ff);
   assign wr_pos  = (wr_sum >= (CAP_W+1)'(cap_ff)) ? wr_sum - (CAP_W+1)'(cap_ff) : wr_sum;
   assign wr_addr = wr_pos[ADDR_W-1:0];

   assign start_inc = CAP_W'(start_ff) + CAP_W'(1);
   assign start_adv = (start_inc >= cap_ff) ? '0 : start_inc[ADDR_W-1:0];

   assign count_min = (len_val < LEN_W'(fill_ff)) ? len_val[CAP_W-1:0] : fill_ff;

   assign status.out_free  = !rsp_valid_ff || rsp_tready;
   assign status.stream    = (cmd_code == CMD_READ) && !err && (fill_ff != '0)
                             && (len_val != '0);
   assign status.count_one = (count_ff == CAP_W'(1));

   always_comb begin
      start_in      = start_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      we            = 1'b0;
      load          = 1'b0;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_dv_in     = out_dv_ff;
      out_last_in   = out_last_ff;
      out_fill_in   = out_fill_ff;

      if (csr_we) begin
         // saturate at the store depth and empty the ring
         cap_in   = (csr_wdata > CSR_W'(DEPTH)) ? CAP_W'(DEPTH) : csr_wdata[CAP_W-1:0];
         start_in = '0;
         fill_in  = '0;
      end else if (cmd.accept) begin
         out_byte_in = '0;
         out_dv_in   = 1'b0;
         out_last_in = 1'b1;
         out_fill_in = fill_ff;
         unique case (cmd_code)
            CMD_WRITE: begin
               load = 1'b1;
               if (err) begin
                  out_status_in = STAT_ERROR;
               end else begin
                  we            = 1'b1;
                  out_status_in = STAT_OK;
                  if (fill_ff < cap_ff) begin
                     fill_in = fill_ff + CAP_W'(1);
                  end else begin
                     start_in = start_adv;
                  end
                  out_fill_in = fill_in;
               end
            end
            CMD_READ: begin
               if (err) begin
                  load          = 1'b1;
                  out_status_in = STAT_ERROR;
               end else if (fill_ff == '0) begin
                  load          = 1'b1;
                  out_status_in = STAT_EMPTY;
               end else if (len_val == '0) begin
                  load          = 1'b1;
                  out_status_in = STAT_OK;
               end else begin
                  count_in = count_min;
               end
            end
            CMD_CLEAR: begin
               load          = 1'b1;
               out_status_in = STAT_OK;
               start_in      = '0;
               fill_in       = '0;
               out_fill_in   = '0;
            end
            default: begin
               // unused code: take the request, give no response
            end
         endcase
      end else if (cmd.step) begin
         load          = 1'b1;
         out_status_in = STAT_OK;
         out_byte_in   = rdata_ff;
         out_dv_in     = 1'b1;
         out_last_in   = (count_ff == CAP_W'(1));
         start_in      = start_adv;
         fill_in       = fill_ff - CAP_W'(1);
         count_in      = count_ff - CAP_W'(1);
         out_fill_in   = fill_in;
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   // read at the next start index, so rdata_ff always holds the oldest byte
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= byte_val;
      end
      if (we && (wr_addr == start_in)) begin
         rdata_ff <= byte_val;
      end else begin
         rdata_ff <= mem[start_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_dv_ff     <= out_dv_in;
      out_last_ff   <= out_last_in;
      out_fill_ff   <= out_fill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({LEN_W'(out_fill_ff), out_byte_ff});
   assign rsp_tuser  = {out_dv_ff, out_status_ff};
   assign rsp_tlast  = out_last_ff;

   `ORB_ASSERT(a_fill_within_cap, clock, reset, fill_ff <= cap_ff, "fill exceeds capacity")
   `ORB_ASSERT(a_start_within_cap, clock, reset, (CAP_W'(start_ff) < cap_ff) || (start_ff == '0), "start index beyond capacity")
   `ORB_ASSERT(a_step_has_count, clock, reset, !cmd.step || (count_ff != '0), "read step with no bytes left")
   `ORB_ASSERT_NEXT(a_step_loads, clock, reset, cmd.step, rsp_valid_ff && out_dv_ff, "read step did not present a byte")

endmodule

`default_nettype wire

@@ rtl/overwrite_ring_buffer.sv @@
// ---------------------------------------------------------------------------
// Overwrite ring buffer
// Byte ring that drops its oldest byte when full, with streaming reads.
// ---------------------------------------------------------------------------
// Response: registered; writes, clears and status-only reads show it in the cycle
//   after the request is taken, a streaming read loads the count, then its first byte.
// Throughput: one request per cycle for writes, clears and status-only reads while
//   responses are taken; a read of N bytes holds the request channel while it loads
//   the count, then one byte per cycle while bytes are taken, via the store read port.
// Reset: synchronous; empty ring, capacity back to full depth; store keeps its data.
`timescale 1ns / 1ps
`default_nettype none

module overwrite_ring_buffer
   import orb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // byte_in[7:0], length[14:8], zero pad
   input  wire logic [CMD_W-1:0]      req_tuser,   // cmd[1:0]
   // response channel
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // byte_out[7:0], fill_level[14:8], zero pad
   output      logic [RSP_USER_W-1:0] rsp_tuser,   // status[1:0], data_valid[2]
   output      logic                  rsp_tlast,
   // capacity register
   input  wire logic                  csr_we,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequence requests: hold off the request channel while a read streams
   // or while the output register still holds an untaken response.
   orb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the store, the ring pointers, the capacity and the response register.
   // A write appends at start plus fill; a full ring advances start instead of
   // fill. A read loads the byte count and then advances start once per byte.
   orb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
